### rtl/aspf_pkg.sv
// Shared types, constants and helper functions of the ADC scan peak-hold filter.
package aspf_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned NUM_PORTS   = 6;
  localparam int unsigned NUM_GROUPS  = 3;
  localparam int unsigned SCALE_BITS  = 24;
  localparam int unsigned CUR_BITS    = 16;
  localparam int unsigned CUR_SHIFT   = 16;
  localparam int unsigned PORT_BITS   = 3;
  localparam int unsigned SLOT_BITS   = 3;
  localparam int unsigned COUNT_BITS  = 3;
  localparam int unsigned GROUP_BITS  = 2;
  localparam int unsigned PHASE_BITS  = 2;
  localparam int unsigned PROD_BITS   = SAMPLE_BITS + SCALE_BITS;

  // Fixed scan order of the motor ports
  localparam logic [PORT_BITS-1:0] ScanOrder [NUM_PORTS] = '{
    3'd4, 3'd5, 3'd6, 3'd2, 3'd3, 3'd1
  };

  localparam logic [PORT_BITS-1:0] FIRST_PORT = 3'd1;
  localparam logic [PORT_BITS-1:0] LAST_PORT  = 3'd6;

  // Phase codes shared by scan and group counters
  localparam logic [PHASE_BITS-1:0] PHASE_0 = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_1 = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_2 = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MASK  = 1'b0;
  localparam logic CFG_SCALE = 1'b1;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_SECOND,
    OP_GROUP
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PEAK,
    BK_MUL,
    BK_OUT
  } back_state_e;

  // One classified sample passed from front to back
  typedef struct packed {
    op_e                    op;
    logic [SLOT_BITS-1:0]   slot;
    logic [GROUP_BITS-1:0]  group;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   emit;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic [SLOT_BITS-1:0] slot;
  } slot_sel_t;

  function automatic logic [SAMPLE_BITS-1:0] max3(input logic [SAMPLE_BITS-1:0] a,
                                                  input logic [SAMPLE_BITS-1:0] b,
                                                  input logic [SAMPLE_BITS-1:0] c);
    logic [SAMPLE_BITS-1:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  // Slot that a port occupies in the scan, given the enable mask
  function automatic slot_sel_t slot_of(input logic [NUM_PORTS-1:0] mask,
                                        input logic [PORT_BITS-1:0] port);
    slot_sel_t            r;
    logic [SLOT_BITS-1:0] n;
    r = '0;
    n = '0;
    for (int k = 0; k < NUM_PORTS; k++) begin
      if (ScanOrder[k] == port) begin
        r.valid = mask[port - 3'd1];
        r.slot  = n;
      end
      if (mask[ScanOrder[k] - 3'd1]) n = n + 3'd1;
    end
    return r;
  endfunction

endpackage

### rtl/aspf_front.sv
// Front end: accepts samples, tracks scan position and phases, classifies each sample.
module aspf_front import aspf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [NUM_PORTS-1:0] mask_i,
  input  logic                 mask_wr_i,
  output entry_t               entry_o,
  output logic                 entry_valid_o
);

  logic [SLOT_BITS-1:0]  slot_pos_q, slot_pos_d;
  logic [PHASE_BITS-1:0] scan_phase_q, scan_phase_d;
  logic [PHASE_BITS-1:0] group_phase_q, group_phase_d;
  logic [COUNT_BITS-1:0] count;
  logic [SLOT_BITS-1:0]  slot;
  logic                  end_scan;
  logic                  accept;

  // Number of enabled ports
  assign count  = COUNT_BITS'($countones(mask_i));
  assign accept = push && !full && (count != '0);

  // Current slot, wrapped if past the enabled count
  assign slot     = (slot_pos_q >= count) ? '0 : slot_pos_q;
  assign end_scan = ({1'b0, slot} + 4'd1) >= {1'b0, count};

  // Classify the beat
  always_comb begin
    entry_o        = '0;
    entry_o.slot   = slot;
    entry_o.sample = sample_i;
    entry_o.group  = (group_phase_q == PHASE_1 || group_phase_q == PHASE_2) ?
                     group_phase_q : PHASE_0;
    entry_o.emit   = end_scan && (scan_phase_q == PHASE_2) && (group_phase_q == PHASE_2);
    case (scan_phase_q)
      PHASE_1: entry_o.op = OP_SECOND;
      PHASE_2: entry_o.op = OP_GROUP;
      default: entry_o.op = OP_FIRST;
    endcase
  end

  assign entry_valid_o = accept;

  // Position and phase update
  always_comb begin
    slot_pos_d    = slot_pos_q;
    scan_phase_d  = scan_phase_q;
    group_phase_d = group_phase_q;
    if (accept) begin
      slot_pos_d = end_scan ? '0 : slot + 3'd1;
      if (end_scan) begin
        case (scan_phase_q)
          PHASE_1: scan_phase_d = PHASE_2;
          PHASE_2: begin
            scan_phase_d = PHASE_0;
            case (group_phase_q)
              PHASE_1: group_phase_d = PHASE_2;
              PHASE_2: group_phase_d = PHASE_0;
              default: group_phase_d = PHASE_1;
            endcase
          end
          default: scan_phase_d = PHASE_1;
        endcase
      end
    end
    if (mask_wr_i) slot_pos_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_pos_q    <= '0;
      scan_phase_q  <= PHASE_0;
      group_phase_q <= PHASE_0;
    end else begin
      slot_pos_q    <= slot_pos_d;
      scan_phase_q  <= scan_phase_d;
      group_phase_q <= group_phase_d;
    end
  end

endmodule

### rtl/aspf_fifo.sv
// Two-entry queue of classified samples between front and back.
module aspf_fifo import aspf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wdata_i,
  input  logic   rd_i,
  output entry_t rdata_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_i) rd_ptr_q <= ~rd_ptr_q;
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/aspf_back.sv
// Back end: updates scan and group stores, then sequences the six filtered results.
module aspf_back import aspf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  entry_t                entry_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic [NUM_PORTS-1:0]  mask_i,
  input  logic [SCALE_BITS-1:0] scale_i,
  input  logic                  pop,
  output logic                  empty,
  output logic [PORT_BITS-1:0]  port_o,
  output logic [SAMPLE_BITS-1:0] peak_code_o,
  output logic [CUR_BITS-1:0]   current_ma_o,
  output logic                  last_o
);

  back_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] first_q  [NUM_PORTS];
  logic [SAMPLE_BITS-1:0] second_q [NUM_PORTS];
  logic [SAMPLE_BITS-1:0] grp_q    [NUM_GROUPS][NUM_PORTS];

  logic [PORT_BITS-1:0]   port_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic                   out_valid_q;
  logic                   out_load;
  logic                   out_free;
  slot_sel_t              sel;
  logic [CUR_BITS-1:0]    cur_sat;

  assign out_free = !out_valid_q || pop;
  assign sel      = slot_of(mask_i, port_q);

  // Saturate the Q16 product
  assign cur_sat = (prod_q[PROD_BITS-1:CUR_SHIFT+CUR_BITS] != '0) ? '1 :
                   prod_q[CUR_SHIFT+CUR_BITS-1:CUR_SHIFT];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_empty_i && entry_i.emit) state_d = BK_PEAK;
      BK_PEAK: state_d = BK_MUL;
      BK_MUL:  state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = (port_q == LAST_PORT) ? BK_IDLE : BK_PEAK;
      default: state_d = BK_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o  = !q_empty_i;
      BK_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      port_q  <= FIRST_PORT;
    end else begin
      state_q <= state_d;
      if (q_pop_o) port_q <= FIRST_PORT;
      else if (out_load) port_q <= port_q + 3'd1;
    end
  end

  // Scan and group stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        first_q[i]  <= '0;
        second_q[i] <= '0;
        for (int g = 0; g < NUM_GROUPS; g++) grp_q[g][i] <= '0;
      end
    end else if (q_pop_o) begin
      case (entry_i.op)
        OP_FIRST:  first_q[entry_i.slot]  <= entry_i.sample;
        OP_SECOND: second_q[entry_i.slot] <= entry_i.sample;
        OP_GROUP:  grp_q[entry_i.group][entry_i.slot] <=
                     max3(first_q[entry_i.slot], second_q[entry_i.slot], entry_i.sample);
        default: ;
      endcase
    end
  end

  // Peak and scaling datapath
  always_ff @(posedge clk_i) begin
    if (state_q == BK_PEAK) begin
      peak_q <= sel.valid ? max3(grp_q[0][sel.slot], grp_q[1][sel.slot], grp_q[2][sel.slot])
                          : '0;
    end
    if (state_q == BK_MUL) begin
      prod_q <= PROD_BITS'(peak_q) * PROD_BITS'(scale_i);
    end
    if (out_load) begin
      port_o       <= port_q;
      peak_code_o  <= peak_q;
      current_ma_o <= cur_sat;
      last_o       <= (port_q == LAST_PORT);
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty = !out_valid_q;

endmodule

### rtl/adc_scan_peak_hold_filter_core.sv
// Top level of the ADC scan peak-hold filter: configuration registers, front, queue, back.
//
// Motor current samples come in on a queue-style input (push/full), one beat per
// conversion, in scan order over the enabled ports (order 4,5,6,2,3,1). Results leave
// through a queue-style output (empty/pop): after every ninth scan the block emits six
// beats, ports 1 to 6, with the nine-scan peak code and its current in mA (Q16 scale,
// saturated at 65535); last marks port 6. A disabled port reports zero.
// Configuration: cfg_valid_i/cfg_ready_o with index 0 = enable mask, 1 = mA per code.
// Writing the mask restarts the current scan at slot 0. Write only while idle.
// Throughput: the front takes one sample per cycle while the two-entry queue has room;
// the back retires one sample per cycle while idle. Each result of the sequence steps the
// back through peak select, multiply and output load, and the queue is not read meanwhile.
// The last sample of the ninth scan passes the queue, the peak register, the product
// register and the output register before the first result is on the ports.
// A stalled receiver holds the output register; the back waits, the queue fills and
// full rises. Reset clears the phases, the stores, the configuration registers and the output valid flag.
module adc_scan_peak_hold_filter_core import aspf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [PORT_BITS-1:0]   port_o,
  output logic [SAMPLE_BITS-1:0] peak_code_o,
  output logic [CUR_BITS-1:0]    current_ma_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [SCALE_BITS-1:0]  cfg_data_i
);

  logic [NUM_PORTS-1:0]  mask_q;
  logic [SCALE_BITS-1:0] scale_q;
  logic                  cfg_wr;
  logic                  mask_wr;
  entry_t                f_entry, q_entry;
  logic                  f_valid;
  logic                  q_pop, q_empty;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign mask_wr     = cfg_wr && (cfg_index_i == CFG_MASK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      scale_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_MASK:  mask_q  <= cfg_data_i[NUM_PORTS-1:0];
        CFG_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aspf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .mask_i        (mask_q),
    .mask_wr_i     (mask_wr),
    .entry_o       (f_entry),
    .entry_valid_o (f_valid)
  );

  aspf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_valid),
    .wdata_i (f_entry),
    .rd_i    (q_pop),
    .rdata_o (q_entry),
    .full_o  (full),
    .empty_o (q_empty)
  );

  aspf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (q_entry),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .mask_i       (mask_q),
    .scale_i      (scale_q),
    .pop          (pop),
    .empty        (empty),
    .port_o       (port_o),
    .peak_code_o  (peak_code_o),
    .current_ma_o (current_ma_o),
    .last_o       (last_o)
  );

endmodule

### rtl/aspf_checker.sv
// Port-level assertions for the ADC scan peak-hold filter, bound to the top level.
module aspf_checker import aspf_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   empty,
  input logic                   pop,
  input logic [PORT_BITS-1:0]   port_o,
  input logic [SAMPLE_BITS-1:0] peak_code_o,
  input logic [CUR_BITS-1:0]    current_ma_o,
  input logic                   last_o
);

  // Result beats carry a real port number
  a_port_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (port_o >= FIRST_PORT && port_o <= LAST_PORT))
    else $error("result port out of range");

  // The run ends exactly on port 6
  a_last_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (port_o == LAST_PORT)))
    else $error("last flag does not match port 6");

  // A zero peak gives zero current
  a_zero_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && peak_code_o == '0) |-> (current_ma_o == '0))
    else $error("nonzero current for zero peak");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(port_o) && $stable(peak_code_o)))
    else $error("waiting result changed");

endmodule

bind adc_scan_peak_hold_filter_core aspf_checker u_aspf_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the ADC scan peak-hold filter core.
`timescale 1ns / 1ps

module tb;
  import aspf_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned ITEM_TARGET  = 150;

  // Port order of one scan
  localparam logic [PORT_BITS-1:0] PORT_SEQ [NUM_PORTS] = '{
    3'd4, 3'd5, 3'd6, 3'd2, 3'd3, 3'd1
  };

  typedef struct packed {
    logic [PORT_BITS-1:0]   port;
    logic [SAMPLE_BITS-1:0] peak;
    logic [CUR_BITS-1:0]    cur;
    logic                   last;
  } port_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [PORT_BITS-1:0]   port_o;
  logic [SAMPLE_BITS-1:0] peak_code_o;
  logic [CUR_BITS-1:0]    current_ma_o;
  logic                   last_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_MASK;
  logic [SCALE_BITS-1:0]  cfg_data = '0;

  adc_scan_peak_hold_filter_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .sample_i     (sample),
    .empty        (empty),
    .pop          (pop),
    .port_o       (port_o),
    .peak_code_o  (peak_code_o),
    .current_ma_o (current_ma_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter state as seen by the checker
  logic [NUM_PORTS-1:0]   en_mask;
  logic [SCALE_BITS-1:0]  scale_q16;
  int unsigned            slot_pos;
  logic [PHASE_BITS-1:0]  scan_ph;
  logic [PHASE_BITS-1:0]  grp_ph;
  logic [SAMPLE_BITS-1:0] scan0_code [NUM_PORTS];
  logic [SAMPLE_BITS-1:0] scan1_code [NUM_PORTS];
  logic [SAMPLE_BITS-1:0] grp_peak [NUM_GROUPS][NUM_PORTS];

  port_result_t           filtered_q [$];
  logic [SAMPLE_BITS-1:0] sample_q [$];
  int unsigned            items_left = 0;
  int unsigned            items_sent = 0;
  int unsigned            fails = 0;
  bit                     in_quiet = 1'b0;
  bit                     out_quiet = 1'b0;
  int unsigned            gap_cnt = 0;
  int unsigned            pop_wait = 0;
  int unsigned            pop_wait_nx;
  int unsigned            idle_cycles = 0;

  function automatic int unsigned enabled_ports();
    int unsigned n;
    n = 0;
    for (int k = 0; k < NUM_PORTS; k++)
      if (en_mask[PORT_SEQ[k] - 1]) n++;
    return n;
  endfunction

  // Scan slot of a port, -1 when the port is off
  function automatic int port_slot(input int unsigned port);
    int n;
    n = 0;
    for (int k = 0; k < NUM_PORTS; k++) begin
      if (PORT_SEQ[k] == port) return en_mask[port - 1] ? n : -1;
      if (en_mask[PORT_SEQ[k] - 1]) n++;
    end
    return -1;
  endfunction

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic model_reset();
    en_mask   = '0;
    scale_q16 = '0;
    slot_pos  = 0;
    scan_ph   = PHASE_0;
    grp_ph    = PHASE_0;
    for (int k = 0; k < NUM_PORTS; k++) begin
      scan0_code[k] = '0;
      scan1_code[k] = '0;
      for (int g = 0; g < NUM_GROUPS; g++) grp_peak[g][k] = '0;
    end
  endtask

  task automatic model_config(input logic idx, input logic [SCALE_BITS-1:0] data);
    if (idx == CFG_MASK) begin
      en_mask  = data[NUM_PORTS-1:0];
      slot_pos = 0;  // scan restarts
    end else begin
      scale_q16 = data;
    end
  endtask

  // Advance the filter by one sample; queue the six port results on a ninth scan
  task automatic model_sample(input logic [SAMPLE_BITS-1:0] code);
    int unsigned            cnt;
    int unsigned            slot;
    int unsigned            g;
    int                     sl;
    bit                     emit;
    logic [SAMPLE_BITS-1:0] pk;
    logic [PROD_BITS-1:0]   prod;
    logic [PROD_BITS-1:0]   shifted;
    port_result_t           r;
    cnt  = enabled_ports();
    emit = 1'b0;
    if (cnt == 0) return;  // nothing enabled: sample dropped
    if (slot_pos >= cnt) slot_pos = 0;
    slot = slot_pos;

    if (scan_ph == PHASE_1) begin
      scan1_code[slot] = code;
    end else if (scan_ph == PHASE_2) begin
      g  = (grp_ph == PHASE_1 || grp_ph == PHASE_2) ? grp_ph : 0;
      pk = scan0_code[slot];
      if (scan1_code[slot] > pk) pk = scan1_code[slot];
      if (code > pk) pk = code;
      grp_peak[g][slot] = pk;
    end else begin
      scan0_code[slot] = code;
    end

    // End of scan: step scan phase, then group phase
    slot_pos = slot + 1;
    if (slot_pos >= cnt) begin
      slot_pos = 0;
      if (scan_ph == PHASE_1) begin
        scan_ph = PHASE_2;
      end else if (scan_ph == PHASE_2) begin
        scan_ph = PHASE_0;
        if (grp_ph == PHASE_2) begin
          grp_ph = PHASE_0;
          emit   = 1'b1;
        end else if (grp_ph == PHASE_1) begin
          grp_ph = PHASE_2;
        end else begin
          grp_ph = PHASE_1;
        end
      end else begin
        scan_ph = PHASE_1;
      end
    end
    if (!emit) return;

    for (int unsigned p = FIRST_PORT; p <= LAST_PORT; p++) begin
      sl    = port_slot(p);
      r     = '0;
      r.port = PORT_BITS'(p);
      r.last = (p == LAST_PORT);
      if (sl >= 0) begin
        pk = grp_peak[0][sl];
        for (int gi = 1; gi < NUM_GROUPS; gi++)
          if (grp_peak[gi][sl] > pk) pk = grp_peak[gi][sl];
        prod    = pk * scale_q16;
        shifted = prod >> CUR_SHIFT;
        r.peak  = pk;
        r.cur   = (shifted > 65535) ? 16'hFFFF : shifted[CUR_BITS-1:0];
      end
      filtered_q.push_back(r);
    end
  endtask

  // Sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push    <= 1'b0;
      gap_cnt <= 0;
    end else if (!(push && full)) begin
      if (push) begin
        model_sample(sample);
        items_left--;
      end
      if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1;
        push    <= 1'b0;
      end else if (sample_q.size() != 0) begin
        sample  <= sample_q.pop_front();
        push    <= 1'b1;
        gap_cnt <= draw_wait(in_quiet);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor: check each beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      pop      <= 1'b0;
      pop_wait <= 0;
    end else if (pop && !empty) begin
      if (filtered_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("unexpected result: port %0d peak %0d current %0d last %0d",
                   port_o, peak_code_o, current_ma_o, last_o);
      end else begin
        port_result_t want;
        want = filtered_q.pop_front();
        if (port_o !== want.port || peak_code_o !== want.peak ||
            current_ma_o !== want.cur || last_o !== want.last) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("mismatch exp/got: port %0d/%0d peak %0d/%0d current %0d/%0d last %0d/%0d",
                     want.port, port_o, want.peak, peak_code_o,
                     want.cur, current_ma_o, want.last, last_o);
        end
      end
      pop_wait_nx = draw_wait(out_quiet);
      pop      <= (pop_wait_nx == 0);
      pop_wait <= pop_wait_nx;
    end else if (!pop) begin
      if (pop_wait != 0) pop_wait <= pop_wait - 1;
      pop <= (pop_wait <= 1);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [SCALE_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mask write with random don't-care upper bits
  task automatic write_mask(input logic [NUM_PORTS-1:0] m);
    logic [SCALE_BITS-1:0] d;
    d = SCALE_BITS'($urandom);
    d[NUM_PORTS-1:0] = m;
    write_reg(CFG_MASK, d);
  endtask

  task automatic queue_sample(input logic [SAMPLE_BITS-1:0] code);
    if (en_mask != '0) items_sent++;
    items_left++;
    sample_q.push_back(code);
  endtask

  // Wait until every sample is in and every result is out, then let the pipe settle
  task automatic wait_idle();
    while (items_left != 0 || filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_code();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [NUM_PORTS-1:0]  m;
    logic [SCALE_BITS-1:0] sc;
    int unsigned           len;
    int unsigned           n_on;
    int unsigned           phases;
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No port enabled after reset: samples are dropped
    queue_sample(12'hFFF);
    queue_sample(12'h000);
    queue_sample(12'hAAA);
    wait_idle();

    // Port 1 alone, full scale: current saturates
    write_reg(CFG_SCALE, 24'hFFFFFF);
    write_mask(6'h01);
    queue_sample(12'hFFF); queue_sample(12'h000); queue_sample(12'h001);
    queue_sample(12'h800); queue_sample(12'h000); queue_sample(12'h000);
    queue_sample(12'h555); queue_sample(12'h007); queue_sample(12'h000);
    wait_idle();

    // Port 6 alone, unity scale
    write_reg(CFG_SCALE, 24'h010000);
    write_mask(6'h20);
    queue_sample(12'h123); queue_sample(12'h000); queue_sample(12'h7FF);
    queue_sample(12'h000); queue_sample(12'h000); queue_sample(12'h000);
    queue_sample(12'h0FF); queue_sample(12'h001); queue_sample(12'h000);
    wait_idle();

    // All ports, zero scale; mask rewrite mid-scan restarts at slot 0
    write_reg(CFG_SCALE, 24'h000000);
    write_mask(6'h3F);
    queue_sample(12'hFFF);
    queue_sample(12'h800);
    wait_idle();
    write_mask(6'h3F);
    queue_sample(12'h400);
    queue_sample(12'hFFF);
    wait_idle();

    // Random phases: new settings, then runs of samples
    phases = 0;
    while (items_sent < ITEM_TARGET && phases < 300) begin
      phases++;
      case ($urandom_range(0, 9))
        0:       m = 6'h3F;
        1:       m = 6'h00;
        2:       m = NUM_PORTS'($urandom);
        default: m = (6'h01 << $urandom_range(0, 5)) |
                     ($urandom_range(0, 1) ? (6'h01 << $urandom_range(0, 5)) : 6'h00);
      endcase
      case ($urandom_range(0, 5))
        0:       sc = 24'h000000;
        1:       sc = 24'hFFFFFF;
        2:       sc = 24'h010000;
        default: sc = SCALE_BITS'($urandom);
      endcase
      if ($urandom_range(0, 1)) begin
        write_mask(m);
        if ($urandom_range(0, 3) != 0) write_reg(CFG_SCALE, sc);
      end else begin
        write_reg(CFG_SCALE, sc);
        write_mask(m);
      end
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      n_on = $countones(m);
      if (n_on == 0)
        len = $urandom_range(1, 5);
      else
        len = 9 * n_on * $urandom_range(1, 2) - $urandom_range(0, n_on - 1);
      repeat (len) queue_sample(rand_code());
      wait_idle();
    end

    if (fails == 0 && filtered_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### adc_scan_peak_hold_filter_core.f
rtl/aspf_pkg.sv
rtl/aspf_front.sv
rtl/aspf_fifo.sv
rtl/aspf_back.sv
rtl/adc_scan_peak_hold_filter_core.sv
rtl/aspf_checker.sv
tb/sv/tb.sv
